/* hdl/bmp_pkg.sv */
// Package for the bar meter with peak hold and decay.
// Holds field widths, register codes, reset values, the log2 fraction table and shared structs.
// No dependencies.
package bmp_pkg;

    localparam int BAND_W      = 6;
    localparam int LEVEL_W     = 16;
    localparam int HEIGHT_W    = 16;
    localparam int SPEED_W     = 20;
    localparam int GAIN_W      = 16;
    localparam int MAXH_W      = 8;
    localparam int ACCEL_W     = 16;
    localparam int GAIN_K_W    = 31;
    localparam int DLOG_W      = 19;
    localparam int HEIGHT_HI_W = 18;

    localparam int NUM_BANDS_DEF = 64;
    localparam int OFIFO_DEPTH   = 8;

    localparam int REG_ADDR_W = 4;
    localparam int REG_DATA_W = 32;

    typedef enum logic [1:0] {
        REG_LOG_GAIN   = 2'd0,
        REG_MAX_HEIGHT = 2'd1,
        REG_BAR_FALL   = 2'd2,
        REG_PEAK_ACCEL = 2'd3
    } t_reg;

    localparam logic [GAIN_W-1:0]  LOG_GAIN_RST   = 16'd2560;
    localparam logic [MAXH_W-1:0]  MAX_HEIGHT_RST = 8'd63;
    localparam logic [HEIGHT_W-1:0] BAR_FALL_RST  = 16'd64;
    localparam logic [ACCEL_W-1:0] PEAK_ACCEL_RST = 16'd17203;

    localparam logic [SPEED_W-1:0] SPEED_RESET = 20'd655;
    localparam logic [SPEED_W-1:0] SPEED_MAX   = 20'hFFFFF;
    localparam logic [14:0]        LOG10_OF_2  = 15'd19728;
    localparam logic [19:0]        LOG2_OFFSET = 20'h80000;

    // log2(1 + k/16) in Q.16, with one extra entry for interpolation
    localparam logic [16:0] FRAC_LOG2 [17] = '{
        17'd0,     17'd5732,  17'd11136, 17'd16248, 17'd21098, 17'd25711,
        17'd30109, 17'd34312, 17'd38336, 17'd42196, 17'd45904, 17'd49472,
        17'd52911, 17'd56229, 17'd59434, 17'd62534, 17'd65536
    };

    typedef struct packed {
        logic [GAIN_W-1:0]   log_gain;
        logic [MAXH_W-1:0]   max_height;
        logic [HEIGHT_W-1:0] bar_fall;
        logic [ACCEL_W-1:0]  peak_accel;
    } t_cfg;

    typedef struct packed {
        logic              vld;
        logic [BAND_W-1:0] band;
        logic              adv;
    } t_tag;

    typedef struct packed {
        logic [BAND_W-1:0]   band;
        logic [HEIGHT_W-1:0] bar;
        logic [HEIGHT_W-1:0] peak;
    } t_beat;

    typedef struct packed {
        logic [SPEED_W-1:0]  speed;
        logic [HEIGHT_W-1:0] peak;
        logic [HEIGHT_W-1:0] bar;
    } t_entry;

endpackage

/* hdl/bar_meter_peak_hold_decay.sv */
// Top level of the bar meter with falling peak hold: config registers, credit, pipeline.
// Depends on bmp_pkg, bmp_log, bmp_state and bmp_ofifo.
//
//   channel   | handshake                   | payload
//   ----------+-----------------------------+-------------------------------------
//   input     | i_in_valid / o_in_ready     | i_band, i_level, i_advance
//   output    | o_out_valid / i_out_ready   | o_out_band, o_bar_level, o_peak_level
//   config    | psel, penable, pwrite/pready| paddr, pwdata, prdata
//
// One beat per cycle while no clear runs and a credit is free; each result passes the
// log stages and the state update into the output queue. The state memory holds
// one word per band and is read one stage before its update; same-band beats take the
// written word forward. After reset a clearing pass writes zero to every band with
// o_in_ready low; config writes are taken throughout.
// An eight-beat output queue with a credit count keeps accepting while the sink stalls,
// until eight beats are in flight or queued.
module bar_meter_peak_hold_decay #(
    parameter int NUM_BANDS = bmp_pkg::NUM_BANDS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input beats
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [bmp_pkg::BAND_W-1:0]         i_band,
    input  logic [bmp_pkg::LEVEL_W-1:0]        i_level,
    input  logic                               i_advance,
    // result beats
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [bmp_pkg::BAND_W-1:0]         o_out_band,
    output logic [bmp_pkg::HEIGHT_W-1:0]       o_bar_level,
    output logic [bmp_pkg::HEIGHT_W-1:0]       o_peak_level,
    // register port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [bmp_pkg::REG_ADDR_W-1:0]     paddr,
    input  logic [bmp_pkg::REG_DATA_W-1:0]     pwdata,
    output logic [bmp_pkg::REG_DATA_W-1:0]     prdata,
    output logic                               pready
);

    localparam int CRD_W = $clog2(bmp_pkg::OFIFO_DEPTH + 1);
    localparam logic [CRD_W-1:0] CRD_MAX = CRD_W'(bmp_pkg::OFIFO_DEPTH);

    bmp_pkg::t_cfg   r_cfg;
    logic [CRD_W-1:0] r_credit;

    bmp_pkg::t_tag   in_tag;
    bmp_pkg::t_tag   look_tag;
    bmp_pkg::t_tag   s4_tag;
    logic            s4_pos;
    logic [bmp_pkg::HEIGHT_HI_W-1:0] s4_hi;
    logic            clearing;
    logic            res_vld;
    bmp_pkg::t_beat  res;
    bmp_pkg::t_beat  out_beat;
    logic            acc_in;
    logic            acc_out;
    logic            cfg_wr;
    bmp_pkg::t_reg   reg_sel;

    // hold input while the clear runs or every queue slot is spoken for
    assign o_in_ready = !clearing && (r_credit < CRD_MAX);
    assign acc_in     = i_in_valid && o_in_ready;
    assign acc_out    = o_out_valid && i_out_ready;

    assign in_tag.vld  = acc_in;
    assign in_tag.band = i_band;
    assign in_tag.adv  = i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_credit <= '0;
        end else begin
            r_credit <= r_credit + CRD_W'(acc_in) - CRD_W'(acc_out);
        end
    end

    // register port: writes complete in the access phase, no wait states
    assign pready  = 1'b1;
    assign reg_sel = bmp_pkg::t_reg'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.log_gain   <= bmp_pkg::LOG_GAIN_RST;
            r_cfg.max_height <= bmp_pkg::MAX_HEIGHT_RST;
            r_cfg.bar_fall   <= bmp_pkg::BAR_FALL_RST;
            r_cfg.peak_accel <= bmp_pkg::PEAK_ACCEL_RST;
        end else if (cfg_wr) begin
            unique case (reg_sel)
                bmp_pkg::REG_LOG_GAIN:   r_cfg.log_gain   <= pwdata[15:0];
                bmp_pkg::REG_MAX_HEIGHT: r_cfg.max_height <= pwdata[7:0];
                bmp_pkg::REG_BAR_FALL:   r_cfg.bar_fall   <= pwdata[15:0];
                bmp_pkg::REG_PEAK_ACCEL: r_cfg.peak_accel <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            bmp_pkg::REG_LOG_GAIN:   prdata = {16'd0, r_cfg.log_gain};
            bmp_pkg::REG_MAX_HEIGHT: prdata = {24'd0, r_cfg.max_height};
            bmp_pkg::REG_BAR_FALL:   prdata = {16'd0, r_cfg.bar_fall};
            bmp_pkg::REG_PEAK_ACCEL: prdata = {16'd0, r_cfg.peak_accel};
            default:                 prdata = '0;
        endcase
    end

    // level to log height, four stages
    bmp_log u_log (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_tag      (in_tag),
        .i_level    (i_level),
        .i_log_gain (r_cfg.log_gain),
        .o_look     (look_tag),
        .o_tag      (s4_tag),
        .o_pos      (s4_pos),
        .o_hi       (s4_hi)
    );

    // per-band bar, peak and fall speed update
    bmp_state #(
        .NUM_BANDS (NUM_BANDS)
    ) u_state (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_look     (look_tag),
        .i_tag      (s4_tag),
        .i_pos      (s4_pos),
        .i_hi       (s4_hi),
        .o_clearing (clearing),
        .o_res_vld  (res_vld),
        .o_res      (res)
    );

    // result queue toward the sink
    bmp_ofifo u_ofifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (res_vld),
        .i_beat  (res),
        .o_vld   (o_out_valid),
        .o_beat  (out_beat),
        .i_rdy   (i_out_ready)
    );

    assign o_out_band   = out_beat.band;
    assign o_bar_level  = out_beat.bar;
    assign o_peak_level = out_beat.peak;

endmodule

/* hdl/bmp_log.sv */
// Log height pipeline: leading one, fraction table, interpolation, gain multiply.
// Depends on bmp_pkg. Four register stages; exposes stage three tag for the state read.
module bmp_log (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  bmp_pkg::t_tag                       i_tag,
    input  logic [bmp_pkg::LEVEL_W-1:0]         i_level,
    input  logic [bmp_pkg::GAIN_W-1:0]          i_log_gain,
    output bmp_pkg::t_tag                       o_look,
    output bmp_pkg::t_tag                       o_tag,
    output logic                                o_pos,
    output logic [bmp_pkg::HEIGHT_HI_W-1:0]     o_hi
);

    logic [bmp_pkg::GAIN_K_W-1:0] r_gain_k;

    bmp_pkg::t_tag                 r_s1_tag;
    logic [bmp_pkg::LEVEL_W-1:0]   r_s1_lvl;

    bmp_pkg::t_tag                 r_s2_tag;
    logic [3:0]                    r_s2_e;
    logic [15:0]                   r_s2_t0;
    logic [12:0]                   r_s2_diff;
    logic [10:0]                   r_s2_rest;
    logic                          r_s2_nz;

    bmp_pkg::t_tag                 r_s3_tag;
    logic [bmp_pkg::DLOG_W-1:0]    r_s3_d;
    logic                          r_s3_pos;

    bmp_pkg::t_tag                 r_s4_tag;
    logic [bmp_pkg::HEIGHT_HI_W-1:0] r_s4_hi;
    logic                          r_s4_pos;

    logic [3:0]  a_lead;
    logic [15:0] a_m;
    logic [4:0]  a_idx;
    logic [16:0] a_t0;
    logic [16:0] a_t1;

    logic [23:0] b_interp;
    logic [16:0] b_frac;
    logic [19:0] b_l2;

    logic [49:0] c_prod;

    // stage A: leading one, normalize, table lookup
    always_comb begin
        a_lead = 4'd0;
        for (int k = 0; k < bmp_pkg::LEVEL_W; k++) begin
            if (r_s1_lvl[k]) begin
                a_lead = 4'(k);
            end
        end
        a_m   = r_s1_lvl << (4'd15 - a_lead);
        a_idx = {1'b0, a_m[14:11]};
        a_t0  = bmp_pkg::FRAC_LOG2[a_idx];
        a_t1  = bmp_pkg::FRAC_LOG2[a_idx + 5'd1];
    end

    // stage B: interpolate and remove the 1/256 offset
    always_comb begin
        b_interp = {11'd0, r_s2_diff} * {13'd0, r_s2_rest};
        b_frac   = {1'b0, r_s2_t0} + 17'(b_interp >> 11);
        b_l2     = {r_s2_e, 16'd0} + {3'd0, b_frac};
    end

    // stage C: scale by log10(2) times gain
    assign c_prod = {31'd0, r_s3_d} * {19'd0, r_gain_k};

    always_ff @(posedge i_clk) begin
        r_gain_k <= bmp_pkg::GAIN_K_W'({15'd0, i_log_gain} * {16'd0, bmp_pkg::LOG10_OF_2});
        if (!i_rst_n) begin
            r_s1_tag.vld <= 1'b0;
            r_s2_tag.vld <= 1'b0;
            r_s3_tag.vld <= 1'b0;
            r_s4_tag.vld <= 1'b0;
        end else begin
            r_s1_tag <= i_tag;
            r_s2_tag <= r_s1_tag;
            r_s3_tag <= r_s2_tag;
            r_s4_tag <= r_s3_tag;
        end
        r_s1_lvl  <= i_level;
        r_s2_e    <= a_lead;
        r_s2_t0   <= a_t0[15:0];
        r_s2_diff <= 13'(a_t1 - a_t0);
        r_s2_rest <= a_m[10:0];
        r_s2_nz   <= (r_s1_lvl != '0);
        r_s3_d    <= bmp_pkg::DLOG_W'(b_l2 - bmp_pkg::LOG2_OFFSET);
        r_s3_pos  <= r_s2_nz && (b_l2 > bmp_pkg::LOG2_OFFSET);
        r_s4_hi   <= c_prod[49:32];
        r_s4_pos  <= r_s3_pos;
    end

    assign o_look = r_s3_tag;
    assign o_tag  = r_s4_tag;
    assign o_pos  = r_s4_pos;
    assign o_hi   = r_s4_hi;

endmodule

/* hdl/bmp_state.sv */
// Per-band state memory with read-modify-write, forwarding and the post-reset clear.
// Depends on bmp_pkg. Read issued from the stage three tag, update done at stage four.
module bmp_state #(
    parameter int NUM_BANDS = bmp_pkg::NUM_BANDS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  bmp_pkg::t_cfg                       i_cfg,
    input  bmp_pkg::t_tag                       i_look,
    input  bmp_pkg::t_tag                       i_tag,
    input  logic                                i_pos,
    input  logic [bmp_pkg::HEIGHT_HI_W-1:0]     i_hi,
    output logic                                o_clearing,
    output logic                                o_res_vld,
    output bmp_pkg::t_beat                      o_res
);

    localparam int AW = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;
    localparam logic [10:0] NB = 11'(NUM_BANDS);
    localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_BANDS - 1);

    bmp_pkg::t_entry r_mem [NUM_BANDS];
    bmp_pkg::t_entry r_rdata;
    bmp_pkg::t_entry r_fwd;
    logic            r_fwd_hit;
    logic            r_clearing;
    logic [AW-1:0]   r_clr_addr;

    bmp_pkg::t_entry cur;
    bmp_pkg::t_entry n_entry;
    logic [bmp_pkg::HEIGHT_W-1:0] cap;
    logic [bmp_pkg::HEIGHT_W-1:0] h;
    logic [bmp_pkg::HEIGHT_W-1:0] pk_fall;
    logic [23:0]                  wide;
    logic [35:0]                  spd_prod;
    logic                         fall;
    logic                         in_range;
    logic                         upd;
    logic                         wr_en;
    logic [AW-1:0]                wr_addr;
    bmp_pkg::t_entry              wr_data;

    assign in_range = ({5'd0, i_tag.band} < NB);
    assign upd      = i_tag.vld && i_tag.adv && in_range;
    assign cur      = r_fwd_hit ? r_fwd : r_rdata;
    assign cap      = {i_cfg.max_height, 8'd0};
    assign h        = !i_pos ? '0 :
                      (i_hi > {2'd0, cap}) ? cap : i_hi[bmp_pkg::HEIGHT_W-1:0];
    assign wide     = {cur.peak, 8'd0};
    assign spd_prod = {16'd0, cur.speed} * {20'd0, i_cfg.peak_accel};

    always_comb begin
        n_entry = cur;
        fall    = 1'b1;
        pk_fall = '0;
        if (h > cur.bar) begin
            n_entry.bar = h;
            if (h > cur.peak) begin
                n_entry.peak  = h;
                n_entry.speed = bmp_pkg::SPEED_RESET;
                fall          = 1'b0;
            end
        end else if (cur.bar != '0) begin
            n_entry.bar = (cur.bar > i_cfg.bar_fall) ? cur.bar - i_cfg.bar_fall : '0;
        end
        if (fall && cur.peak != '0) begin
            if (wide > {4'd0, cur.speed}) begin
                pk_fall = 16'((wide - {4'd0, cur.speed}) >> 8);
            end
            n_entry.speed = (spd_prod[35:14] > {2'd0, bmp_pkg::SPEED_MAX}) ?
                            bmp_pkg::SPEED_MAX : spd_prod[33:14];
            n_entry.peak  = (pk_fall < n_entry.bar) ? n_entry.bar : pk_fall;
        end
    end

    assign wr_en   = r_clearing || upd;
    assign wr_addr = r_clearing ? r_clr_addr : AW'(i_tag.band);
    assign wr_data = r_clearing ? '0 : n_entry;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rdata   <= r_mem[AW'(i_look.band)];
        // same band written at the read edge: take the written word instead
        r_fwd     <= n_entry;
        r_fwd_hit <= upd && i_look.vld && (i_look.band == i_tag.band);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            if (r_clr_addr == LAST_ADDR) begin
                r_clearing <= 1'b0;
            end else begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
        end
    end

    assign o_clearing = r_clearing;
    assign o_res_vld  = i_tag.vld;
    assign o_res.band = i_tag.band;
    assign o_res.bar  = !in_range ? '0 : (i_tag.adv ? n_entry.bar : cur.bar);
    assign o_res.peak = !in_range ? '0 : (i_tag.adv ? n_entry.peak : cur.peak);

endmodule

/* hdl/bmp_ofifo.sv */
// Output queue for result beats, absorbs the pipeline while the sink stalls.
// Depends on bmp_pkg.
module bmp_ofifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_wr,
    input  bmp_pkg::t_beat  i_beat,
    output logic            o_vld,
    output bmp_pkg::t_beat  o_beat,
    input  logic            i_rdy
);

    localparam int PW = $clog2(bmp_pkg::OFIFO_DEPTH);

    bmp_pkg::t_beat r_q [bmp_pkg::OFIFO_DEPTH];
    logic [PW:0]    r_wr_ptr;
    logic [PW:0]    r_rd_ptr;

    assign o_vld  = (r_wr_ptr != r_rd_ptr);
    assign o_beat = r_q[r_rd_ptr[PW-1:0]];

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_q[r_wr_ptr[PW-1:0]] <= i_beat;
        end
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else begin
            if (i_wr) begin
                r_wr_ptr <= r_wr_ptr + (PW+1)'(1);
            end
            if (o_vld && i_rdy) begin
                r_rd_ptr <= r_rd_ptr + (PW+1)'(1);
            end
        end
    end

endmodule
